// File: rtl/rmef_pkg.sv
// Shared constants and types for the RSSI median and exponential average filter.
// Used by rmef_ctrl, rmef_datapath and rssi_median_ema_filter; depends on nothing.
`timescale 1ns / 1ps

package rmef_pkg;

    localparam int WINDOW_SIZE = 7;
    localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

    localparam int SAMPLE_W = 8;
    localparam int AVG_W = 16;
    localparam int COUNT_OUT_W = 3;
    localparam int Q8_SHIFT = 8;
    localparam int EMA_SHIFT = 2;
    localparam int SUM_W = AVG_W + EMA_SHIFT + 1;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;
    localparam logic signed [SAMPLE_W-1:0] INVALID_SAMPLE = 8'sh7F;

    typedef struct packed {
        logic store;
        logic clear;
        logic scan_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic takes_sample;
        logic is_clear;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/rmef_ctrl.sv
// Controller state machine for the RSSI filter: input handshake and scan sequencing.
// Depends on rmef_pkg for the command and status types.
`timescale 1ns / 1ps

module rmef_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rmef_pkg::status_t status,
    output rmef_pkg::cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.is_clear)
                begin
                    cmd.clear = 1'b1;
                end
                else if (accept && status.takes_sample)
                begin
                    cmd.store = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/rmef_datapath.sv
// Datapath for the RSSI filter: sample ring, rank-based median scan, Q8 average
// and the output register. Depends on rmef_pkg for constants and types.
`timescale 1ns / 1ps

module rmef_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rmef_pkg::cmd_t                         cmd,
    output rmef_pkg::status_t                      status,
    input  logic                                   action,
    input  logic signed [rmef_pkg::SAMPLE_W-1:0]   sample_dbm,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [rmef_pkg::SAMPLE_W-1:0]   median_dbm,
    output logic signed [rmef_pkg::AVG_W-1:0]      filtered_q8,
    output logic [rmef_pkg::COUNT_OUT_W-1:0]       sample_count
);

    logic signed [rmef_pkg::SAMPLE_W-1:0] window_reg [rmef_pkg::WINDOW_SIZE];
    logic [rmef_pkg::PTR_W-1:0]           wr_pos_reg;
    logic [rmef_pkg::PTR_W-1:0]           wr_pos_next;
    logic [rmef_pkg::CNT_W-1:0]           filled_reg;
    logic [rmef_pkg::CNT_W-1:0]           filled_next;
    logic [rmef_pkg::PTR_W-1:0]           idx_reg;
    logic [rmef_pkg::PTR_W-1:0]           idx_next;
    logic signed [rmef_pkg::SAMPLE_W-1:0] med_reg;
    logic                                 avg_valid_reg;
    logic signed [rmef_pkg::AVG_W-1:0]    avg_reg;
    logic signed [rmef_pkg::AVG_W-1:0]    avg_next;
    logic                                 out_valid_reg;
    logic signed [rmef_pkg::SAMPLE_W-1:0] out_med_reg;
    logic signed [rmef_pkg::AVG_W-1:0]    out_avg_reg;
    logic [rmef_pkg::COUNT_OUT_W-1:0]     out_cnt_reg;

    logic signed [rmef_pkg::SAMPLE_W-1:0] cur;
    logic [rmef_pkg::WINDOW_SIZE-1:0]     below;
    logic [rmef_pkg::CNT_W-1:0]           rank;
    logic signed [rmef_pkg::SUM_W-1:0]    sum;
    logic signed [rmef_pkg::SUM_W-1:0]    quot;

    assign status.takes_sample = (action == rmef_pkg::ACTION_SAMPLE)
                                 && (sample_dbm != rmef_pkg::INVALID_SAMPLE);
    assign status.is_clear = (action == rmef_pkg::ACTION_CLEAR);
    assign status.scan_last = (rmef_pkg::CNT_W'(idx_reg) == (filled_reg - 1'b1));
    assign status.out_free = !out_valid_reg || !out_stall;

    assign wr_pos_next = (wr_pos_reg == rmef_pkg::PTR_W'(rmef_pkg::WINDOW_SIZE - 1))
                         ? '0 : wr_pos_reg + 1'b1;
    assign filled_next = (filled_reg == rmef_pkg::CNT_W'(rmef_pkg::WINDOW_SIZE))
                         ? filled_reg : filled_reg + 1'b1;
    assign idx_next = (cmd.store || status.scan_last) ? '0 : idx_reg + 1'b1;

    // The entry under scan is the median when exactly filled/2 entries sort before it.
    // Equal values are ordered by position so that every entry gets a distinct rank.
    assign cur = window_reg[idx_reg];

    always_comb
    begin
        rank = '0;
        for (int j = 0; j < rmef_pkg::WINDOW_SIZE; j++)
        begin
            below[j] = (rmef_pkg::CNT_W'(j) < filled_reg)
                       && ((window_reg[j] < cur)
                           || ((window_reg[j] == cur) && (rmef_pkg::PTR_W'(j) < idx_reg)));
            rank = rank + rmef_pkg::CNT_W'(below[j]);
        end
    end

    // Average = (3*avg + 256*median)/4, rounded toward zero; 256*median when unseeded.
    always_comb
    begin
        sum = (rmef_pkg::SUM_W'(avg_reg) <<< 1) + rmef_pkg::SUM_W'(avg_reg)
              + (rmef_pkg::SUM_W'(med_reg) <<< rmef_pkg::Q8_SHIFT);
        quot = sum >>> rmef_pkg::EMA_SHIFT;
        if (sum[rmef_pkg::SUM_W-1] && (sum[rmef_pkg::EMA_SHIFT-1:0] != '0))
        begin
            quot = quot + 1'b1;
        end
        if (avg_valid_reg)
        begin
            avg_next = quot[rmef_pkg::AVG_W-1:0];
        end
        else
        begin
            avg_next = {med_reg, {rmef_pkg::Q8_SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rmef_pkg::WINDOW_SIZE; i++)
            begin
                window_reg[i] <= '0;
            end
            wr_pos_reg <= '0;
            filled_reg <= '0;
            idx_reg <= '0;
            avg_valid_reg <= 1'b0;
            avg_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < rmef_pkg::WINDOW_SIZE; i++)
                begin
                    window_reg[i] <= '0;
                end
                wr_pos_reg <= '0;
                filled_reg <= '0;
                avg_valid_reg <= 1'b0;
                avg_reg <= '0;
            end
            else if (cmd.store)
            begin
                window_reg[wr_pos_reg] <= sample_dbm;
                wr_pos_reg <= wr_pos_next;
                filled_reg <= filled_next;
            end
            if (cmd.store || cmd.scan_en)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.finish)
            begin
                avg_reg <= avg_next;
                avg_valid_reg <= 1'b1;
            end
            out_valid_reg <= cmd.finish || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en && (rank == (filled_reg >> 1)))
        begin
            med_reg <= cur;
        end
        if (cmd.finish)
        begin
            out_med_reg <= med_reg;
            out_avg_reg <= avg_next;
            out_cnt_reg <= rmef_pkg::COUNT_OUT_W'(filled_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign median_dbm = out_med_reg;
    assign filtered_q8 = out_avg_reg;
    assign sample_count = out_cnt_reg;

endmodule

// File: rtl/rssi_median_ema_filter.sv
// Top level of the RSSI median and exponential average filter.
// Instantiates rmef_ctrl and rmef_datapath; depends on rmef_pkg.
//
//  Channel  Handshake            Payload
//  input    in_valid, in_stall   action, sample_dbm
//  output   out_valid, out_stall median_dbm, filtered_q8, sample_count
//
// A stored sample first writes the ring, then a serial rank scan visits each filled
// entry to find the median, and a final step updates the average and the result.
// Clear items and invalid samples are taken without leaving idle and give no result.
// Reset empties the ring and the average; the result register lets the next item
// be taken while a result is still stalled, and the scan waits only at the final load.
`timescale 1ns / 1ps

module rssi_median_ema_filter
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   action,
    input  logic signed [rmef_pkg::SAMPLE_W-1:0]   sample_dbm,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [rmef_pkg::SAMPLE_W-1:0]   median_dbm,
    output logic signed [rmef_pkg::AVG_W-1:0]      filtered_q8,
    output logic [rmef_pkg::COUNT_OUT_W-1:0]       sample_count
);

    rmef_pkg::cmd_t    cmd;
    rmef_pkg::status_t status;

    rmef_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rmef_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .sample_dbm   (sample_dbm),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_dbm   (median_dbm),
        .filtered_q8  (filtered_q8),
        .sample_count (sample_count)
    );

`ifndef SYNTH
    a_sample_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == rmef_pkg::ACTION_SAMPLE)
         && (sample_dbm != rmef_pkg::INVALID_SAMPLE)) |=> in_stall)
        else $error("A stored sample did not start the median scan.");

    a_clear_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == rmef_pkg::ACTION_CLEAR)) |=> !in_stall)
        else $error("A clear item left the block busy.");

    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("A result appeared without a finished scan.");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_count != '0))
        else $error("A result carries an empty window count.");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for rssi_median_ema_filter: directed and random RSSI items,
// an in-order predictor of the median window and Q8 average, and a field-by-field check.
// Depends on rmef_pkg and the rssi_median_ema_filter RTL.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_RESULTS = 1600;
    localparam int EMA_OLD_WEIGHT = 3;
    localparam int EMA_TOTAL_WEIGHT = 4;
    localparam int Q8_ONE = 256;

    typedef struct {
        logic                                 act;
        logic signed [rmef_pkg::SAMPLE_W-1:0] dbm;
        bit                                   pause;
    } rssi_item_t;

    typedef struct {
        logic signed [rmef_pkg::SAMPLE_W-1:0]  median;
        logic signed [rmef_pkg::AVG_W-1:0]     filtered;
        logic [rmef_pkg::COUNT_OUT_W-1:0]      count;
    } filter_result_t;

    typedef enum {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_ALTERNATE} stall_mode_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic                                   action = rmef_pkg::ACTION_SAMPLE;
    logic signed [rmef_pkg::SAMPLE_W-1:0]   sample_dbm = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic signed [rmef_pkg::SAMPLE_W-1:0]   median_dbm;
    logic signed [rmef_pkg::AVG_W-1:0]      filtered_q8;
    logic [rmef_pkg::COUNT_OUT_W-1:0]       sample_count;

    rssi_item_t      pending[$];
    filter_result_t  owed[$];
    int              mismatches = 0;
    int              cycles = 0;

    logic signed [rmef_pkg::SAMPLE_W-1:0] ring [rmef_pkg::WINDOW_SIZE];
    int              ring_pos = 0;
    int              ring_fill = 0;
    bit              avg_seeded = 1'b0;
    int              avg_q8 = 0;

    logic            nothing_owed = 1'b1;
    int              items_taken = 0;
    logic            sender_done = 1'b0;

    int              settle_left = 0;
    bit              pause_wait = 1'b0;
    int              gap_left = 0;
    int              burst_left = 0;
    rssi_item_t      next_item;

    int              hold_left = 0;
    int              hold_count = 0;
    int              seg_left = 0;
    stall_mode_t     stall_mode = STALL_NONE;
    bit              stall_toggle = 1'b0;

    rssi_median_ema_filter DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .sample_dbm   (sample_dbm),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_dbm   (median_dbm),
        .filtered_q8  (filtered_q8),
        .sample_count (sample_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic clear_filter();
        for (int k = 0; k < rmef_pkg::WINDOW_SIZE; k++)
        begin
            ring[k] = '0;
        end
        ring_pos = 0;
        ring_fill = 0;
        avg_seeded = 1'b0;
        avg_q8 = 0;
    endtask

    // Applies one accepted item to the predicted window and average.
    task automatic track_item(input logic act, input logic signed [rmef_pkg::SAMPLE_W-1:0] dbm);
        int             vals [rmef_pkg::WINDOW_SIZE];
        int             n;
        int             j;
        int             v;
        int             med;
        filter_result_t r;

        if (act == rmef_pkg::ACTION_CLEAR)
        begin
            clear_filter();
            return;
        end
        if (dbm == rmef_pkg::INVALID_SAMPLE)
        begin
            return;
        end
        ring[ring_pos] = dbm;
        ring_pos = (ring_pos + 1) % rmef_pkg::WINDOW_SIZE;
        if (ring_fill < rmef_pkg::WINDOW_SIZE)
        begin
            ring_fill++;
        end
        n = ring_fill;
        for (int i = 0; i < n; i++)
        begin
            vals[i] = int'(ring[i]);
        end
        for (int i = 1; i < n; i++)
        begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > v)
            begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        med = vals[n / 2];
        if (!avg_seeded)
        begin
            avg_q8 = med * Q8_ONE;
            avg_seeded = 1'b1;
        end
        else
        begin
            avg_q8 = (avg_q8 * EMA_OLD_WEIGHT + med * Q8_ONE) / EMA_TOTAL_WEIGHT;
        end
        r.median = rmef_pkg::SAMPLE_W'(med);
        r.filtered = rmef_pkg::AVG_W'(avg_q8);
        r.count = rmef_pkg::COUNT_OUT_W'(ring_fill);
        owed.push_back(r);
    endtask

    task automatic queue_item(input logic act, input int dbm);
        rssi_item_t it;

        it.act = act;
        it.dbm = rmef_pkg::SAMPLE_W'(dbm);
        it.pause = 1'b0;
        pending.push_back(it);
    endtask

    task automatic queue_pause();
        rssi_item_t it;

        it.act = rmef_pkg::ACTION_SAMPLE;
        it.dbm = '0;
        it.pause = 1'b1;
        pending.push_back(it);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The sender only moves on once the current item is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= rmef_pkg::ACTION_SAMPLE;
            sample_dbm <= '0;
            sender_done <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (settle_left > 0)
            begin
                settle_left--;
                in_valid <= 1'b0;
            end
            else if (pause_wait)
            begin
                in_valid <= 1'b0;
                if (nothing_owed)
                begin
                    pause_wait = 1'b0;
                    settle_left = SETTLE_CYCLES;
                end
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending.size() == 0)
            begin
                in_valid <= 1'b0;
                sender_done <= 1'b1;
            end
            else
            begin
                next_item = pending.pop_front();
                if (next_item.pause)
                begin
                    pause_wait = 1'b1;
                    settle_left = 2;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    action <= next_item.act;
                    sample_dbm <= next_item.dbm;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left = $urandom_range(1, 14);
                    end
                end
            end
        end
    end

    // The receiver stalls on random patterns and twice holds off for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_count < 2 && items_taken >= ((hold_count == 0) ? 400 : 1100))
        begin
            hold_left = 250;
            hold_count++;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 80);
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            end
            seg_left--;
            stall_toggle = !stall_toggle;
            case (stall_mode)
                STALL_NONE:      out_stall <= 1'b0;
                STALL_HALF:      out_stall <= ($urandom_range(0, 1) == 1);
                STALL_LIGHT:     out_stall <= ($urandom_range(0, 4) == 0);
                STALL_ALTERNATE: out_stall <= stall_toggle;
                default:         out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_filter();
            nothing_owed <= 1'b1;
            items_taken <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed.size() == 0)
                begin
                    report_mismatch("result with nothing owed, median", int'(median_dbm), 0);
                end
                else
                begin
                    filter_result_t want;

                    want = owed.pop_front();
                    if (median_dbm !== want.median)
                    begin
                        report_mismatch("median_dbm", int'(median_dbm), int'(want.median));
                    end
                    if (filtered_q8 !== want.filtered)
                    begin
                        report_mismatch("filtered_q8", int'(filtered_q8), int'(want.filtered));
                    end
                    if (sample_count !== want.count)
                    begin
                        report_mismatch("sample_count", int'(sample_count), int'(want.count));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                track_item(action, sample_dbm);
                items_taken <= items_taken + 1;
            end
            nothing_owed <= (owed.size() == 0);
        end
    end

    initial
    begin
        int   planned;
        int   r;
        int   run;
        int   v;
        bit   paused_mid;

        // An invalid marker into an empty window, then the field extremes and a ring wrap.
        queue_item(rmef_pkg::ACTION_SAMPLE, int'(rmef_pkg::INVALID_SAMPLE));
        queue_item(rmef_pkg::ACTION_SAMPLE, -128);
        queue_item(rmef_pkg::ACTION_SAMPLE, 126);
        queue_item(rmef_pkg::ACTION_SAMPLE, 0);
        queue_item(rmef_pkg::ACTION_SAMPLE, -1);
        queue_item(rmef_pkg::ACTION_SAMPLE, int'(rmef_pkg::INVALID_SAMPLE));
        queue_item(rmef_pkg::ACTION_SAMPLE, 1);
        queue_item(rmef_pkg::ACTION_SAMPLE, 85);
        queue_item(rmef_pkg::ACTION_SAMPLE, -86);
        queue_item(rmef_pkg::ACTION_SAMPLE, 126);
        queue_item(rmef_pkg::ACTION_SAMPLE, 126);
        queue_item(rmef_pkg::ACTION_SAMPLE, -128);
        queue_item(rmef_pkg::ACTION_CLEAR, -1);
        queue_item(rmef_pkg::ACTION_CLEAR, 0);
        queue_item(rmef_pkg::ACTION_SAMPLE, int'(rmef_pkg::INVALID_SAMPLE));
        queue_item(rmef_pkg::ACTION_SAMPLE, -60);
        queue_item(rmef_pkg::ACTION_SAMPLE, -70);
        queue_item(rmef_pkg::ACTION_SAMPLE, -50);
        queue_item(rmef_pkg::ACTION_CLEAR, int'(rmef_pkg::INVALID_SAMPLE));
        for (int i = 0; i < 5; i++)
        begin
            queue_item(rmef_pkg::ACTION_SAMPLE, -128);
        end
        queue_pause();

        planned = 0;
        paused_mid = 1'b0;
        while (planned < RANDOM_RESULTS)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                queue_item(rmef_pkg::ACTION_CLEAR, $urandom_range(0, 255));
            end
            else if (r < 5)
            begin
                queue_item(rmef_pkg::ACTION_SAMPLE, int'(rmef_pkg::INVALID_SAMPLE));
            end
            else if (r < 8)
            begin
                run = $urandom_range(5, 14);
                v = ($urandom_range(0, 1) == 1) ? 126 : -128;
                for (int i = 0; i < run; i++)
                begin
                    queue_item(rmef_pkg::ACTION_SAMPLE, v);
                end
                planned += run;
            end
            else if (r < 22)
            begin
                v = $urandom_range(0, 255);
                queue_item(rmef_pkg::ACTION_SAMPLE, v);
                if (v != int'(rmef_pkg::INVALID_SAMPLE))
                begin
                    planned++;
                end
            end
            else
            begin
                queue_item(rmef_pkg::ACTION_SAMPLE, int'($urandom_range(0, 60)) - 95);
                planned++;
            end
            if (!paused_mid && planned >= RANDOM_RESULTS / 2)
            begin
                queue_pause();
                paused_mid = 1'b1;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!(sender_done && nothing_owed))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed.size() != 0)
        begin
            report_mismatch("results never delivered", 0, owed.size());
        end
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
